// ===== hw/rtl/surface_normal_strip_to_triangles_macros.svh =====
// Assertion macros shared by the checker of the strip-to-triangle block.
// Depends on nothing; included by the checker file.
`ifndef SURFACE_NORMAL_STRIP_TO_TRIANGLES_MACROS_SVH
`define SURFACE_NORMAL_STRIP_TO_TRIANGLES_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SNS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error(msg);

// Next-cycle implication checked outside reset.
`define SNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

// ===== hw/rtl/snstt_pkg.sv =====
// Package for the strip-to-triangle block: op codes, fixed-point constants
// and the shared-unit command type. Depends on nothing.
package snstt_pkg;
	localparam logic [2:0] OP_POINT = 3'd0;
	localparam logic [2:0] OP_UPART = 3'd1;
	localparam logic [2:0] OP_VPART = 3'd2;
	localparam logic [2:0] OP_TEX   = 3'd3;
	localparam logic [2:0] OP_START = 3'd4;
	localparam logic [2:0] OP_SWAP  = 3'd5;

	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

	// Commands for the shared arithmetic unit.
	localparam logic [1:0] ALU_MUL  = 2'd0; // acc <= a*b
	localparam logic [1:0] ALU_MSUB = 2'd1; // acc <= acc - a*b
	localparam logic [1:0] ALU_MADD = 2'd2; // acc <= acc + a*b (unsigned squares)

	typedef struct packed {
		logic              go;
		logic [1:0]        cmd;
		logic signed [32:0] a;
		logic signed [32:0] b;
	} alu_req_t;
endpackage

// ===== hw/rtl/snstt_mac.sv =====
// Shared multiply-accumulate unit of the strip-to-triangle block.
// Depends on snstt_pkg. One 33x33 signed multiply per cycle into a 66-bit accumulator.
module snstt_mac (
	input  logic                clk,
	input  snstt_pkg::alu_req_t req,
	output logic signed [65:0]  acc
);
	import snstt_pkg::*;
	logic signed [65:0] prod_s1;
	logic [1:0]         cmd_s1;
	logic               go_s1;
	logic signed [65:0] acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= req.a * req.b;
		cmd_s1  <= req.cmd;
		go_s1   <= req.go;
		if (go_s1) begin
			case (cmd_s1)
				ALU_MUL:  acc_q <= prod_s1;
				ALU_MSUB: acc_q <= acc_q - prod_s1;
				ALU_MADD: acc_q <= acc_q + prod_s1;
				default:  acc_q <= acc_q;
			endcase
		end
	end
	assign acc = acc_q;
endmodule

// ===== hw/rtl/snstt_div.sv =====
// Restoring integer square root and divider of the strip-to-triangle block.
// Depends on nothing else; one result bit per cycle for both operations.
module snstt_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start_sqrt,
	input  logic        start_div,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        busy,
	output logic [63:0] result
);
	logic [63:0] rem_q, res_q, bit_q, num_q;
	logic [31:0] den_q;
	logic [6:0]  cnt_q;
	logic        sq_q, busy_q;
	logic [64:0] trial;
	logic [64:0] drem;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign drem  = {rem_q, num_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start_sqrt) begin
			busy_q <= 1'b1;
			sq_q   <= 1'b1;
			rem_q  <= num;
			res_q  <= '0;
			bit_q  <= 64'h4000_0000_0000_0000;
			cnt_q  <= 7'd32;
		end else if (start_div) begin
			busy_q <= 1'b1;
			sq_q   <= 1'b0;
			rem_q  <= '0;
			num_q  <= num;
			den_q  <= den;
			res_q  <= '0;
			cnt_q  <= 7'd64;
		end else if (busy_q) begin
			if (sq_q) begin
				if ({1'b0, rem_q} >= trial) begin
					rem_q <= rem_q - trial[63:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				num_q <= num_q << 1;
				if (drem >= {33'd0, den_q}) begin
					rem_q <= drem[63:0] - {32'd0, den_q};
					res_q <= {res_q[62:0], 1'b1};
				end else begin
					rem_q <= drem[63:0];
					res_q <= {res_q[62:0], 1'b0};
				end
			end
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1)
				busy_q <= 1'b0;
		end
	end
	assign busy   = busy_q | start_sqrt | start_div;
	assign result = res_q;
endmodule

// ===== hw/rtl/surface_normal_strip_to_triangles.sv =====
// Top level of the strip-to-triangle block with its sequencer.
// Depends on snstt_pkg, snstt_mac and snstt_div.
//
// This block turns a tessellator event stream into independent triangles
// with a unit surface normal at every vertex. One word is taken at a time;
// ready stays low while a point is being worked on. A partial, texture,
// start or swap word is stored or acted on in the idle state. A point runs
// through one shared multiply-accumulate unit, waiting for the accumulator
// before each difference or sum is read: the partial correction (only in
// homogeneous mode), the cross product, a step to find the largest component,
// the one-bit-per-cycle scaling and the sum of squares. A bit-serial unit
// then takes the square root and the three divisions. From the third point
// of a strip on, two stored words leave in slot order, then the current
// vertex with last_of_triangle set. The output register keeps the result
// until taken, and the next input word is only accepted once all three have
// gone. The homogeneous_mode register resets to one and should only be
// written while the block is idle.
module surface_normal_strip_to_triangles (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         op,
	input  logic signed [31:0] comp_x,
	input  logic signed [31:0] comp_y,
	input  logic signed [31:0] comp_z,
	input  logic signed [31:0] comp_w,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [31:0] pos_w,
	output logic signed [31:0] norm_x,
	output logic signed [31:0] norm_y,
	output logic signed [31:0] norm_z,
	output logic signed [31:0] tex_s,
	output logic signed [31:0] tex_t,
	output logic               tex_valid,
	output logic               last_of_triangle
);
	import snstt_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CORR  = 4'd1; // partial correction products
	localparam logic [3:0] ST_CROSS = 4'd2; // cross product
	localparam logic [3:0] ST_SCALE = 4'd3; // normalize magnitudes
	localparam logic [3:0] ST_SQ    = 4'd4; // sum of squares
	localparam logic [3:0] ST_SQRT  = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_EMIT  = 4'd7;
	localparam logic [3:0] ST_STORE = 4'd8;
	localparam logic [3:0] ST_MAX   = 4'd9; // capture the largest magnitude

	logic [3:0] state_q;
	logic       hmode_q;
	logic signed [31:0] up_q [4];
	logic signed [31:0] vp_q [4];
	logic signed [31:0] cpos_q [2][4];
	logic signed [31:0] cnrm_q [2][3];
	logic signed [31:0] ctex_q [2][2];
	logic signed [31:0] tex_q [2];
	logic       tgiven_q;
	logic [1:0] vcnt_q;
	logic       slot_q;
	logic       tsent_q;

	logic signed [31:0] pos_q [4];
	logic signed [65:0] cr_q [3];
	logic signed [31:0] nrm_q [3];
	logic [65:0] msh_q;
	logic [63:0] sumsq_q;
	logic [31:0] len_q;
	logic [4:0]  step_q;
	logic [1:0]  idx_q;
	logic [1:0]  emit_q;
	logic [1:0]  wait_q;

	alu_req_t           req;
	logic signed [65:0] acc;
	logic        sqrt_go, div_go, dbusy;
	logic [63:0] dnum, dres;
	logic        emit_fire;

	snstt_mac u_mac (.clk(clk), .req(req), .acc(acc));
	snstt_div u_div (
		.clk(clk), .arst_n(arst_n), .start_sqrt(sqrt_go), .start_div(div_go),
		.num(dnum), .den(len_q), .busy(dbusy), .result(dres)
	);

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !out_valid;
	assign emit_fire = (state_q == ST_EMIT) && (vcnt_q == 2'd2) && (!out_valid || out_ready);

	// Magnitude helper and largest magnitude of the working cross components.
	function automatic logic [65:0] mag66(input logic signed [65:0] v);
		mag66 = v[65] ? -v : v;
	endfunction

	logic [65:0] mmax;
	logic [65:0] m0, m1, m2;
	always_comb begin
		m0 = mag66(cr_q[0]);
		m1 = mag66(cr_q[1]);
		m2 = mag66(cr_q[2]);
		mmax = m0;
		if (m1 > mmax) mmax = m1;
		if (m2 > mmax) mmax = m2;
	end

	// Operand selection for the shared multiplier, driven by the step count.
	// Correction step k (0..11): partial p = k/6, component i, two terms.
	logic signed [31:0] dsel [4];
	logic [2:0] ci;
	always_comb begin
		req = '{go: 1'b0, cmd: ALU_MUL, a: '0, b: '0};
		ci  = '0;
		for (int j = 0; j < 4; j++)
			dsel[j] = (step_q >= 5'd6) ? vp_q[j] : up_q[j];
		case (state_q)
			ST_CORR: begin
				if (wait_q == 2'd0) begin
					ci = (step_q >= 5'd6) ? 3'(step_q - 5'd6) : step_q[2:0];
					req.go = 1'b1;
					if (!ci[0]) begin
						req.cmd = ALU_MUL;
						req.a = 33'(dsel[ci[2:1]]);
						req.b = 33'(pos_q[3]);
					end else begin
						req.cmd = ALU_MSUB;
						req.a = 33'(dsel[3]);
						req.b = 33'(pos_q[ci[2:1]]);
					end
				end
			end
			ST_CROSS: begin
				if (wait_q == 2'd0) begin
					req.go = 1'b1;
					req.cmd = step_q[0] ? ALU_MSUB : ALU_MUL;
					case (step_q[2:1])
						2'd0: begin
							req.a = 33'(step_q[0] ? up_q[2] : up_q[1]);
							req.b = 33'(step_q[0] ? vp_q[1] : vp_q[2]);
						end
						2'd1: begin
							req.a = 33'(step_q[0] ? up_q[0] : up_q[2]);
							req.b = 33'(step_q[0] ? vp_q[2] : vp_q[0]);
						end
						default: begin
							req.a = 33'(step_q[0] ? up_q[1] : up_q[0]);
							req.b = 33'(step_q[0] ? vp_q[0] : vp_q[1]);
						end
					endcase
				end
			end
			ST_SQ: begin
				if (wait_q == 2'd0) begin
					req.go = 1'b1;
					req.cmd = (step_q == 5'd0) ? ALU_MUL : ALU_MADD;
					req.a = 33'(cr_q[step_q[1:0]]);
					req.b = 33'(cr_q[step_q[1:0]]);
				end
			end
			default: ;
		endcase
	end

	logic signed [65:0] corr_sh;
	logic signed [31:0] corr_sat;
	always_comb begin
		corr_sh = acc >>> 16;
		if (corr_sh > 66'sd2147483647)
			corr_sat = 32'h7FFF_FFFF;
		else if (corr_sh < -66'sd2147483648)
			corr_sat = 32'h8000_0000;
		else
			corr_sat = corr_sh[31:0];
	end

	logic [63:0] div_mag;
	logic [31:0] dq;
	assign div_mag = 64'(mag66(cr_q[idx_q])) << 30;
	assign dnum = sqrt_go ? sumsq_q : (div_mag + 64'(len_q >> 1));
	assign dq = dres[31:0];

	logic [1:0] es;
	assign es = emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			hmode_q   <= 1'b1;
			tgiven_q  <= 1'b0;
			vcnt_q    <= '0;
			slot_q    <= 1'b0;
			tsent_q   <= 1'b0;
			out_valid <= 1'b0;
			wait_q    <= '0;
			step_q    <= '0;
			idx_q     <= '0;
			emit_q    <= '0;
			sqrt_go   <= 1'b0;
			div_go    <= 1'b0;
			for (int j = 0; j < 4; j++) begin
				up_q[j] <= '0;
				vp_q[j] <= '0;
			end
			for (int s = 0; s < 2; s++) begin
				ctex_q[s][0] <= '0;
				ctex_q[s][1] <= '0;
			end
			tex_q[0] <= '0;
			tex_q[1] <= '0;
		end else begin
			sqrt_go <= 1'b0;
			div_go  <= 1'b0;
			if (out_valid && out_ready && !emit_fire)
				out_valid <= 1'b0;
			if (cfg_valid && cfg_ready)
				hmode_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						case (op)
							OP_POINT: begin
								pos_q[0] <= comp_x;
								pos_q[1] <= comp_y;
								pos_q[2] <= comp_z;
								pos_q[3] <= hmode_q ? comp_w : ONE_Q16;
								step_q   <= '0;
								wait_q   <= '0;
								state_q  <= hmode_q ? ST_CORR : ST_CROSS;
							end
							OP_UPART: begin
								up_q[0] <= comp_x; up_q[1] <= comp_y;
								up_q[2] <= comp_z; up_q[3] <= comp_w;
							end
							OP_VPART: begin
								vp_q[0] <= comp_x; vp_q[1] <= comp_y;
								vp_q[2] <= comp_z; vp_q[3] <= comp_w;
							end
							OP_TEX: begin
								tex_q[0] <= comp_x;
								tex_q[1] <= comp_y;
								tgiven_q <= 1'b1;
							end
							OP_START: begin
								slot_q   <= 1'b0;
								vcnt_q   <= '0;
								tgiven_q <= 1'b0;
							end
							OP_SWAP: begin
								if (tsent_q) slot_q <= ~slot_q;
							end
							default: ;
						endcase
					end
				end
				// Each pair of products issues, then the state waits for the accumulator.
				ST_CORR: begin
					if (wait_q == 2'd0) begin
						if (step_q[0]) wait_q <= 2'd1;
						else step_q <= step_q + 5'd1;
					end else if (wait_q == 2'd1) begin
						wait_q <= 2'd2;
					end else begin
						wait_q <= 2'd0;
						if (step_q >= 5'd6)
							vp_q[2'((step_q - 5'd6) >> 1)] <= corr_sat;
						else
							up_q[step_q[2:1]] <= corr_sat;
						if (step_q == 5'd11) begin
							step_q  <= '0;
							state_q <= ST_CROSS;
						end else begin
							step_q <= step_q + 5'd1;
						end
					end
				end
				ST_CROSS: begin
					if (wait_q == 2'd0) begin
						if (step_q[0]) wait_q <= 2'd1;
						else step_q <= step_q + 5'd1;
					end else if (wait_q == 2'd1) begin
						wait_q <= 2'd2;
					end else begin
						wait_q <= 2'd0;
						cr_q[step_q[2:1]] <= acc;
						if (step_q == 5'd5) begin
							step_q  <= '0;
							state_q <= ST_MAX;
						end else begin
							step_q <= step_q + 5'd1;
						end
					end
				end
				// The shift count follows the exact largest magnitude, shifted alongside.
				ST_MAX: begin
					msh_q   <= mmax;
					state_q <= ST_SCALE;
				end
				// One bit of shift per cycle until the largest lies in [2^30, 2^31); a zero vector gives a zero normal.
				ST_SCALE: begin
					if (msh_q == '0) begin
						for (int j = 0; j < 3; j++) nrm_q[j] <= '0;
						emit_q  <= '0;
						state_q <= ST_EMIT;
					end else if (msh_q >= 66'h8000_0000) begin
						for (int j = 0; j < 3; j++) cr_q[j] <= cr_q[j] >>> 1;
						msh_q <= msh_q >> 1;
					end else if (msh_q < 66'h4000_0000) begin
						for (int j = 0; j < 3; j++) cr_q[j] <= cr_q[j] <<< 1;
						msh_q <= msh_q << 1;
					end else begin
						step_q  <= '0;
						wait_q  <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (wait_q == 2'd0) begin
						wait_q <= 2'd1;
					end else if (wait_q == 2'd1) begin
						wait_q <= 2'd2;
					end else begin
						wait_q <= 2'd0;
						if (step_q[1:0] == 2'd2) begin
							sumsq_q <= acc[63:0];
							sqrt_go <= 1'b1;
							state_q <= ST_SQRT;
						end else begin
							step_q <= step_q + 5'd1;
						end
					end
				end
				ST_SQRT: begin
					if (!sqrt_go && !dbusy) begin
						len_q   <= (dres[31:0] == '0) ? 32'd1 : dres[31:0];
						idx_q   <= '0;
						div_go  <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!div_go && !dbusy) begin
						nrm_q[idx_q] <= cr_q[idx_q][65] ? -dq : dq;
						if (idx_q == 2'd2) begin
							emit_q  <= '0;
							state_q <= ST_EMIT;
						end else begin
							idx_q  <= idx_q + 2'd1;
							div_go <= 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (vcnt_q != 2'd2) begin
						state_q <= ST_STORE;
					end else if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						tex_valid <= tgiven_q;
						if (es == 2'd2) begin
							pos_x <= pos_q[0]; pos_y <= pos_q[1];
							pos_z <= pos_q[2]; pos_w <= pos_q[3];
							norm_x <= nrm_q[0]; norm_y <= nrm_q[1]; norm_z <= nrm_q[2];
							tex_s <= tgiven_q ? tex_q[0] : '0;
							tex_t <= tgiven_q ? tex_q[1] : '0;
							last_of_triangle <= 1'b1;
							tsent_q <= 1'b1;
							state_q <= ST_STORE;
						end else begin
							pos_x <= cpos_q[es[0]][0]; pos_y <= cpos_q[es[0]][1];
							pos_z <= cpos_q[es[0]][2]; pos_w <= cpos_q[es[0]][3];
							norm_x <= cnrm_q[es[0]][0]; norm_y <= cnrm_q[es[0]][1];
							norm_z <= cnrm_q[es[0]][2];
							tex_s <= tgiven_q ? ctex_q[es[0]][0] : '0;
							tex_t <= tgiven_q ? ctex_q[es[0]][1] : '0;
							last_of_triangle <= 1'b0;
							emit_q <= emit_q + 2'd1;
						end
					end
				end
				ST_STORE: begin
					for (int j = 0; j < 4; j++) cpos_q[slot_q][j] <= pos_q[j];
					for (int j = 0; j < 3; j++) cnrm_q[slot_q][j] <= nrm_q[j];
					ctex_q[slot_q][0] <= tex_q[0];
					ctex_q[slot_q][1] <= tex_q[1];
					slot_q <= ~slot_q;
					if (vcnt_q != 2'd2) vcnt_q <= vcnt_q + 2'd1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/snstt_checker.sv =====
// Port-level checker for the strip-to-triangle block, bound to the top level.
// Depends on the macros header.
`include "surface_normal_strip_to_triangles_macros.svh"
module snstt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pos_x,
	input logic        last_of_triangle,
	input logic        tex_valid,
	input logic [31:0] tex_s
);
	`SNS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pos_x), "result word dropped or changed while stalled")
	`SNS_ASSERT_IMP(a_no_take_while_out, clk, arst_n, out_valid, !in_ready, "input taken while a result word waits")
	`SNS_ASSERT_IMP(a_tex_zero, clk, arst_n, out_valid && !tex_valid, tex_s == 32'd0, "texture not zero without a given coordinate")
	`SNS_ASSERT_NEXT(a_last_ends, clk, arst_n, out_valid && out_ready && last_of_triangle, !out_valid, "word after the last of a triangle")
endmodule

bind surface_normal_strip_to_triangles snstt_checker u_snstt_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .pos_x(pos_x), .last_of_triangle(last_of_triangle),
	.tex_valid(tex_valid), .tex_s(tex_s)
);
